// ===== rtl/core/sha1_pkg.sv =====
// Shared constants, command types and helpers of the SHA-1 hash engine.
package sha1_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenOffset  = 56;
	localparam int unsigned Rounds     = 80;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [6:0] ROUND_LAST = 7'(Rounds - 1);
	localparam logic [5:0] CNT_LAST   = 6'(BlockBytes - 1);
	localparam logic [5:0] CNT_LEN    = 6'(LenOffset);

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} sha1_src_t;

	typedef struct packed {
		logic      shift_en;
		sha1_src_t byte_src;
		logic [2:0] len_idx;
		logic      count_bits;
		logic      round_start;
		logic      round_en;
		logic [6:0] round;
		logic      chain_add;
		logic      digest_load;
		logic      msg_clear;
	} sha1_cmd_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

// ===== rtl/core/sha1_dp.sv =====
// Datapath: block shift register, round registers, chaining words, bit count, digest.
module sha1_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha1_pkg::sha1_cmd_t cmd,
	input  logic [7:0]          data_byte,
	output logic [159:0]        digest
);

	logic [511:0] blk_q;
	logic [63:0]  bits_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h_q [5];
	logic [159:0] digest_q;

	logic [7:0]  pad_byte;
	logic [5:0]  len_lsb;
	logic [31:0] w_t, w_new, f, k, t;

	assign len_lsb = {3'(3'd7 - cmd.len_idx), 3'b000};

	always_comb begin
		case (cmd.byte_src)
			sha1_pkg::SRC_IN:   pad_byte = data_byte;
			sha1_pkg::SRC_MARK: pad_byte = sha1_pkg::PAD_MARK;
			sha1_pkg::SRC_LEN:  pad_byte = bits_q[len_lsb +: 8];
			default:            pad_byte = 8'h00;
		endcase
	end

	assign w_t   = blk_q[511:480];
	assign w_new = sha1_pkg::rotl1(blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w_t);

	always_comb begin
		if (cmd.round < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K_CH;
		end else if (cmd.round < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K_PA1;
		end else if (cmd.round < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K_MAJ;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K_PA2;
		end
		t = sha1_pkg::rotl5(a_q) + f + e_q + w_t + k;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], pad_byte};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.round_start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= sha1_pkg::rotl30(b_q);
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.digest_load) begin
			digest_q <= {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			h_q[0] <= sha1_pkg::H0_INIT;
			h_q[1] <= sha1_pkg::H1_INIT;
			h_q[2] <= sha1_pkg::H2_INIT;
			h_q[3] <= sha1_pkg::H3_INIT;
			h_q[4] <= sha1_pkg::H4_INIT;
		end else begin
			if (cmd.msg_clear) begin
				bits_q <= '0;
				h_q[0] <= sha1_pkg::H0_INIT;
				h_q[1] <= sha1_pkg::H1_INIT;
				h_q[2] <= sha1_pkg::H2_INIT;
				h_q[3] <= sha1_pkg::H3_INIT;
				h_q[4] <= sha1_pkg::H4_INIT;
			end else begin
				if (cmd.count_bits) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.chain_add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
			end
		end
	end

	assign digest = digest_q;

endmodule

// ===== rtl/core/sha1_ctrl.sv =====
// Controller: byte intake, padding sequence, round count and result handshake.
module sha1_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                byte_valid,
	input  logic                is_last,
	output logic                out_valid,
	input  logic                out_ready,
	output sha1_pkg::sha1_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic [6:0] rnd_q;
	logic       mark_q;
	logic       spill_q;
	logic       pend_q;
	logic       final_q;
	logic       ovalid_q;

	logic accept, take_in, blk_full, load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign accept    = in_valid && in_ready;
	assign take_in   = accept && byte_valid;
	assign blk_full  = cmd.shift_en && (cnt_q == sha1_pkg::CNT_LAST);
	assign load_out  = (state_q == ST_DONE) && (!ovalid_q || out_ready);

	always_comb begin
		cmd             = '0;
		cmd.byte_src    = sha1_pkg::SRC_IN;
		cmd.len_idx     = cnt_q[2:0];
		cmd.round       = rnd_q;
		cmd.count_bits  = take_in;
		cmd.shift_en    = take_in || (state_q == ST_PAD);
		cmd.round_start = blk_full;
		cmd.round_en    = (state_q == ST_ROUND);
		cmd.chain_add   = (state_q == ST_ADD);
		cmd.digest_load = load_out;
		cmd.msg_clear   = load_out;
		if (state_q == ST_PAD) begin
			if (!mark_q) begin
				cmd.byte_src = sha1_pkg::SRC_MARK;
			end else if (spill_q || (cnt_q < sha1_pkg::CNT_LEN)) begin
				cmd.byte_src = sha1_pkg::SRC_ZERO;
			end else begin
				cmd.byte_src = sha1_pkg::SRC_LEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rnd_q    <= '0;
			mark_q   <= 1'b0;
			spill_q  <= 1'b0;
			pend_q   <= 1'b0;
			final_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (blk_full) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						pend_q  <= is_last;
						final_q <= 1'b0;
					end else if (accept && is_last) begin
						state_q <= ST_PAD;
						pend_q  <= 1'b1;
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end
					if (blk_full) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						final_q <= mark_q && !spill_q;
						spill_q <= 1'b0;
					end else if (!mark_q) begin
						spill_q <= (cnt_q >= sha1_pkg::CNT_LEN);
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1_pkg::ROUND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (final_q) begin
						state_q <= ST_DONE;
					end else if (pend_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						pend_q  <= 1'b0;
						mark_q  <= 1'b0;
						spill_q <= 1'b0;
						final_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= sha1_pkg::ROUND_LAST))
		else $error("round counter beyond last round");

	a_pad_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> pend_q)
		else $error("padding without a closed message");

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		final_q |-> (mark_q && pend_q))
		else $error("length block without end marker");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == sha1_pkg::ROUND_LAST) |=> (state_q == ST_ADD))
		else $error("chain update missed after last round");

	a_done_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (final_q && (cnt_q == 6'd0)))
		else $error("digest stage reached with block partly filled");

endmodule

// ===== rtl/core/sha1_hash_engine.sv =====
// Top level of the SHA-1 hash engine: byte stream in, 160-bit digest out.
//
// Input: one message byte per beat on s_axis. s_axis_tuser is the byte-valid
// flag; a beat with tuser low and tlast high closes the message without a
// byte, one with both low changes nothing. s_axis_tlast marks the final beat.
// Output: one beat per message on m_axis, the five digest words H0..H4 with
// H0 in the lowest 32 bits.
// Timing: byte beats are taken only while the core is idle. Each 64th byte
// starts a compression (80 rounds in one shared round unit plus the chaining
// update), during which no bytes are taken. After tlast the padding bytes are
// shifted in one per cycle up to the block end, followed by one or two
// compressions; the digest is then registered in the output register once
// that register is free.
// Reset: arst_n clears the controller, the bit count and loads the initial
// chaining words; the block is ready in the first cycle after release.
// Stall: the digest sits in an output register, so new bytes are taken while
// it waits; a second digest holds in the core until the first has left.
module sha1_hash_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tuser,  // [0] byte_valid
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata   // digest_word0 .. digest_word4, 32 bits each
);

	sha1_pkg::sha1_cmd_t cmd;

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.byte_valid (s_axis_tuser),
		.is_last    (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (s_axis_tdata),
		.digest    (m_axis_tdata)
	);

endmodule

// ===== sim/sha1_hash_engine_test.sv =====
// Self-checking testbench of the SHA-1 hash engine with a built-in digest predictor.
module sha1_hash_engine_test;

	typedef logic [4:0][31:0] digest_t;

	localparam digest_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};
	localparam logic [31:0] K_ROUND0 = 32'h5A827999;
	localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam int          LEN_POS    = 56;
	localparam int          BLOCK_LEN  = 64;
	localparam int          DRAIN_CYCLES = 400;
	localparam longint      CYCLE_LIMIT  = 1000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;

	sha1_hash_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	digest_t     chain_h;
	logic [7:0]  blk [BLOCK_LEN];
	int unsigned blk_fill;
	logic [63:0] msg_bits;
	digest_t     pending_digests [$];
	int          gap_pct;
	int          stall_pct;
	int          mismatches;
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress_chain();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_ROUND0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_ROUND1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_ROUND2;
			end else begin
				f = b ^ c ^ d;
				k = K_ROUND3;
			end
			t = rotl(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void clear_message();
		chain_h  = SHA1_IV;
		blk_fill = 0;
		msg_bits = '0;
	endfunction

	// absorb one accepted beat; a closing beat pads, finishes and queues the digest
	function automatic void absorb_beat(input logic [7:0] b, input logic v, input logic l);
		int unsigned n;
		if (v) begin
			blk[blk_fill] = b;
			blk_fill++;
			msg_bits += 64'd8;
			if (blk_fill == BLOCK_LEN) begin
				compress_chain();
				blk_fill = 0;
			end
		end
		if (l) begin
			n = blk_fill;
			blk[n] = PAD_BYTE;
			n++;
			if (n > LEN_POS) begin
				while (n < BLOCK_LEN) begin
					blk[n] = 8'h00;
					n++;
				end
				compress_chain();
				n = 0;
			end
			while (n < LEN_POS) begin
				blk[n] = 8'h00;
				n++;
			end
			for (int i = 0; i < 8; i++)
				blk[LEN_POS + i] = msg_bits[63 - 8*i -: 8];
			compress_chain();
			pending_digests.push_back(chain_h);
			clear_message();
		end
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic v, input logic l);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= v;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		absorb_beat(b, v, l);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// random bytes; the close rides on the last byte or follows as a beat of its own
	task automatic send_message(input int len, inout int sent);
		logic split_close;
		split_close = (len == 0) || ($urandom_range(3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			send_beat(8'($urandom_range(255)), 1'b1, !split_close && (i == len - 1));
			sent++;
		end
		if (split_close) begin
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
			sent++;
		end
	endtask

	task automatic test_directed();
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b1);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_block_boundaries();
		int lens [13];
		int sent;
		lens = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		sent = 0;
		foreach (lens[i])
			send_message(lens[i], sent);
	endtask

	task automatic test_random(input int target);
		int sent;
		int len;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(200);
			else
				len = $urandom_range(70);
			send_message(len, sent);
		end
	endtask

	// hold the sender until every digest has left
	task automatic test_drain_pause();
		int sent;
		sent = 0;
		for (int m = 0; m < 4; m++) begin
			send_message($urandom_range(40), sent);
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (pending_digests.size() != 0);
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_digest
		digest_t want;
		digest_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_digests.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected digest, expected none, actual %h", $time, got);
			end else begin
				want = pending_digests.pop_front();
				for (int i = 0; i < 5; i++)
					if (got[i] !== want[i]) begin
						mismatches++;
						$display("%0t: digest_word%0d expected %h actual %h",
							$time, i, want[i], got[i]);
					end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		mismatches     = 0;
		cycles         = 0;
		gap_pct        = 10;
		stall_pct      = 83;
		clear_message();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_block_boundaries();
		test_random(30);
		gap_pct   = 83;
		stall_pct = 10;
		test_random(30);
		test_drain_pause();
		gap_pct   = 0;
		stall_pct = 0;
		test_random(30);
		go_idle();

		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_digests.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sha1_pkg.sv
rtl/core/sha1_dp.sv
rtl/core/sha1_ctrl.sv
rtl/core/sha1_hash_engine.sv
sim/sha1_hash_engine_test.sv
